// ----- hw/rtl/wall_layer_rc_lumping_macros.svh -----
// Assertion macros for the wall layer RC lumping block.
// Included by the top level; no other dependencies.
`ifndef WALL_LAYER_RC_LUMPING_MACROS_SVH
`define WALL_LAYER_RC_LUMPING_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define WLRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wlrc assertion failed");
// Next-cycle implication, disabled during reset
`define WLRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wlrc assertion failed");
`else
`define WLRC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WLRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/wlrc_pkg.sv -----
// Shared types, widths, codes and helpers for the wall layer RC lumping block.
// No dependencies.
`default_nettype none
package wlrc_pkg;

    localparam int OUT_FRAC_BITS = 16;

    localparam int FIELD_W = 16;
    localparam int CAP_W   = 48;
    localparam int RES_W   = 48;
    localparam int WSUM_W  = 64;
    localparam int PROD_W  = 64;
    localparam int ACC_W   = 96;
    localparam int TCAP_W  = 36;
    localparam int KW_W    = 32;
    localparam int ST_W    = 2;
    localparam int DIV_W   = 64;
    localparam int DNUM_W  = 48;
    localparam int DCNT_W  = 6;
    localparam int NUM_W   = CAP_W + OUT_FRAC_BITS;
    localparam int NHI_W   = NUM_W - KW_W;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_ZCAP  = 2'd1;
    localparam logic [ST_W-1:0] ST_ZCOND = 2'd2;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd3;

    localparam logic [CAP_W-1:0]  CAP_MAX  = {CAP_W{1'b1}};
    localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};
    localparam logic [KW_W-1:0]   KW_MAX   = {KW_W{1'b1}};

    // Capacity scaling by 1/10000: drop four bits (divide by 16), then
    // multiply by ceil(2^54/625) and keep bits from 54 up. Exact for every
    // 48-bit capacity sum.
    localparam int                CAP_PRE    = 4;
    localparam logic [CAP_W-1:0]  CAP_RECIP  = 48'd28823037615172;
    localparam int                TCAP_SHIFT = 54;

    localparam logic [DCNT_W-1:0] DIV_STEPS_FULL = 6'd48;
    localparam logic [DCNT_W-1:0] DIV_STEPS_Q    = 6'd32;

    typedef struct packed {
        logic [FIELD_W-1:0] thickness;
        logic [FIELD_W-1:0] conductivity;
        logic [FIELD_W-1:0] density;
        logic [FIELD_W-1:0] heat_capacity;
        logic               last_layer;
        logic               k_zero;
    } t_layer;

    typedef struct packed {
        logic              start;
        logic [DCNT_W-1:0] steps;
        logic [DNUM_W-1:0] num;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DNUM_W-1:0] quo;
    } t_div_rsp;

    // Saturating 48-bit add
    function automatic logic [CAP_W-1:0] sat_add48(input logic [CAP_W-1:0] a,
                                                   input logic [CAP_W-1:0] b);
        logic [CAP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CAP_W] ? CAP_MAX : s[CAP_W-1:0];
    endfunction

    // Saturating 64-bit add
    function automatic logic [WSUM_W-1:0] sat_add64(input logic [WSUM_W-1:0] a,
                                                    input logic [WSUM_W-1:0] b);
        logic [WSUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WSUM_W] ? WSUM_MAX : s[WSUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/wall_layer_rc_lumping.sv -----
// Wall layer RC lumping. Send the layers of one wall from the outside in, one
// request each, and mark the innermost with last_layer; that request yields one
// result with total capacity, outer and inner conductance (Q16.16) and status.
// The time of an ordinary layer is set by the 48-step resistance division in
// the shared bit-serial divider (skipped when its conductivity is zero); the
// last layer adds two products built from 16-bit slices (Rtot*Cw, and the
// capacity times a reciprocal of 10000) and up to two 32-step conductance
// divisions, plus any time the result waits on a stall.
// A two-entry queue takes new layers while the previous one is being worked on,
// and the result sits in an output register until it is taken.
`default_nettype none
`include "wall_layer_rc_lumping_macros.svh"
module wall_layer_rc_lumping (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [wlrc_pkg::FIELD_W-1:0] i_thickness,
    input  wire logic [wlrc_pkg::FIELD_W-1:0] i_conductivity,
    input  wire logic [wlrc_pkg::FIELD_W-1:0] i_density,
    input  wire logic [wlrc_pkg::FIELD_W-1:0] i_heat_capacity,
    input  wire logic                         i_last_layer,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [wlrc_pkg::TCAP_W-1:0]       o_total_capacity,
    output logic [wlrc_pkg::KW_W-1:0]         o_outer_conductance,
    output logic [wlrc_pkg::KW_W-1:0]         o_inner_conductance,
    output logic [wlrc_pkg::ST_W-1:0]         o_status
);

    logic               q_valid;
    logic               q_pop;
    wlrc_pkg::t_layer   q_item;
    wlrc_pkg::t_div_req div_req;
    wlrc_pkg::t_div_rsp div_rsp;

    // Accept and queue layers
    wlrc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_thickness     (i_thickness),
        .i_conductivity  (i_conductivity),
        .i_density       (i_density),
        .i_heat_capacity (i_heat_capacity),
        .i_last_layer    (i_last_layer),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    // Shared divider
    wlrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Layer arithmetic and result
    wlrc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_q_pop             (q_pop),
        .o_div_req           (div_req),
        .i_div_rsp           (div_rsp),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_total_capacity    (o_total_capacity),
        .o_outer_conductance (o_outer_conductance),
        .o_inner_conductance (o_inner_conductance),
        .o_status            (o_status)
    );

    `WLRC_ASSERT_IMPL(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
    `WLRC_ASSERT_IMPL(a_div_done_after_busy, i_clk, i_rst_n, div_rsp.done, $past(div_rsp.busy))
    `WLRC_ASSERT_IMPL(a_error_zero_kw, i_clk, i_rst_n,
        o_valid && (o_status == wlrc_pkg::ST_ZCAP || o_status == wlrc_pkg::ST_ZCOND),
        o_outer_conductance == '0 && o_inner_conductance == '0)
    `WLRC_ASSERT_NEXT(a_pop_has_item, i_clk, i_rst_n, q_pop && !q_valid, 1'b0)

endmodule
`default_nettype wire

// ----- hw/rtl/wlrc_front.sv -----
// Front end: accepts layer requests, flags zero conductivity, queues them.
// Depends on wlrc_pkg.
`default_nettype none
module wlrc_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [wlrc_pkg::FIELD_W-1:0] i_thickness,
    input  wire logic [wlrc_pkg::FIELD_W-1:0] i_conductivity,
    input  wire logic [wlrc_pkg::FIELD_W-1:0] i_density,
    input  wire logic [wlrc_pkg::FIELD_W-1:0] i_heat_capacity,
    input  wire logic                         i_last_layer,
    output logic                              o_q_valid,
    output wlrc_pkg::t_layer                  o_q_item,
    input  wire logic                         i_q_pop
);

    wlrc_pkg::t_layer r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             push;
    logic             pop;

    assign o_stall   = r_cnt[1];
    assign push      = i_valid && !r_cnt[1];
    assign o_q_valid = r_cnt != 2'd0;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Store the classified request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{thickness:     i_thickness,
                             conductivity:  i_conductivity,
                             density:       i_density,
                             heat_capacity: i_heat_capacity,
                             last_layer:    i_last_layer,
                             k_zero:        i_conductivity == '0};
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/wlrc_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on wlrc_pkg.
`default_nettype none
module wlrc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire wlrc_pkg::t_div_req i_req,
    output wlrc_pkg::t_div_rsp      o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [wlrc_pkg::DCNT_W-1:0]     r_cnt;
    logic [wlrc_pkg::DIV_W-1:0]      r_rem;
    logic [wlrc_pkg::DNUM_W-1:0]     r_num;
    logic [wlrc_pkg::DNUM_W-1:0]     r_quo;
    logic [wlrc_pkg::DIV_W-1:0]      r_den;
    logic [wlrc_pkg::DIV_W:0]        shifted;
    logic [wlrc_pkg::DIV_W:0]        diff;
    logic                            ge;
    logic [wlrc_pkg::DIV_W-1:0]      n_rem;

    // Shift in one dividend bit and trial-subtract
    always_comb begin
        shifted = {r_rem, r_num[wlrc_pkg::DNUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = shifted >= {1'b0, r_den};
        n_rem   = ge ? diff[wlrc_pkg::DIV_W-1:0] : shifted[wlrc_pkg::DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[wlrc_pkg::DNUM_W-2:0], 1'b0};
            r_quo <= {r_quo[wlrc_pkg::DNUM_W-2:0], ge};
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quo: r_quo};

endmodule
`default_nettype wire

// ----- hw/rtl/wlrc_back.sv -----
// Back end: per-layer arithmetic, running sums and the final wall result.
// Depends on wlrc_pkg; drives the shared divider through its request struct.
`default_nettype none
module wlrc_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_valid,
    input  wire wlrc_pkg::t_layer          i_q_item,
    output logic                           o_q_pop,
    output wlrc_pkg::t_div_req             o_div_req,
    input  wire wlrc_pkg::t_div_rsp        i_div_rsp,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [wlrc_pkg::TCAP_W-1:0]    o_total_capacity,
    output logic [wlrc_pkg::KW_W-1:0]      o_outer_conductance,
    output logic [wlrc_pkg::KW_W-1:0]      o_inner_conductance,
    output logic [wlrc_pkg::ST_W-1:0]      o_status
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_P     = 4'd1;
    localparam logic [3:0] S_C     = 4'd2;
    localparam logic [3:0] S_CW    = 4'd3;
    localparam logic [3:0] S_RW    = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_RCSET = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_TCAP  = 4'd9;
    localparam logic [3:0] S_Q1    = 4'd10;
    localparam logic [3:0] S_Q1W   = 4'd11;
    localparam logic [3:0] S_Q2    = 4'd12;
    localparam logic [3:0] S_Q2W   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;
    localparam logic [3:0] S_TCSET = 4'd15;

    logic [3:0]                      r_state;
    logic [3:0]                      n_state;
    wlrc_pkg::t_layer                r_item;
    logic [wlrc_pkg::CAP_W-1:0]      r_csum;
    logic [wlrc_pkg::RES_W-1:0]      r_rsum;
    logic [wlrc_pkg::WSUM_W-1:0]     r_wsum;
    logic                            r_err;
    logic [wlrc_pkg::PROD_W-1:0]     r_prod;
    logic [wlrc_pkg::ACC_W-1:0]      r_acc;
    logic [wlrc_pkg::CAP_W-1:0]      r_c;
    logic [wlrc_pkg::RES_W-1:0]      r_r;
    logic [wlrc_pkg::CAP_W-1:0]      r_ma;
    logic [wlrc_pkg::CAP_W-1:0]      r_mb;
    logic [2:0]                      r_j;
    logic                            r_rc_pass;
    logic                            r_tc_pass;
    logic [wlrc_pkg::WSUM_W-1:0]     r_d2;
    logic                            r_sat;
    logic [wlrc_pkg::TCAP_W-1:0]     r_tcap;
    logic [wlrc_pkg::KW_W-1:0]       r_kw1;
    logic [wlrc_pkg::KW_W-1:0]       r_kw2;
    logic                            r_ov;
    logic [wlrc_pkg::TCAP_W-1:0]     r_o_tcap;
    logic [wlrc_pkg::KW_W-1:0]       r_o_kw1;
    logic [wlrc_pkg::KW_W-1:0]       r_o_kw2;
    logic [wlrc_pkg::ST_W-1:0]       r_o_st;

    logic [wlrc_pkg::CAP_W-1:0]      mul_a;
    logic [wlrc_pkg::FIELD_W-1:0]    mul_b;
    logic [1:0]                      idx;
    logic [wlrc_pkg::ACC_W-1:0]      part;
    logic [wlrc_pkg::RES_W-1:0]      q_r;
    logic [wlrc_pkg::RES_W-1:0]      rmid;
    logic [wlrc_pkg::WSUM_W-1:0]     rc;
    logic [wlrc_pkg::NUM_W-1:0]      n_full;
    logic [wlrc_pkg::DIV_W-1:0]      nhi;
    logic                            over1;
    logic                            over2;
    logic                            out_free;
    logic [19:0]                     den_k;
    logic [wlrc_pkg::ST_W-1:0]       n_st;

    assign idx      = r_j[2:1];
    assign out_free = !r_ov || !i_stall;
    assign q_r      = r_item.k_zero ? '0 : i_div_rsp.quo;
    assign rmid     = wlrc_pkg::sat_add48(r_rsum, {1'b0, q_r[wlrc_pkg::RES_W-1:1]});
    assign rc       = r_acc[wlrc_pkg::ACC_W-1:32];
    assign n_full   = {r_csum, {wlrc_pkg::OUT_FRAC_BITS{1'b0}}};
    assign nhi      = {{(wlrc_pkg::DIV_W-wlrc_pkg::NHI_W){1'b0}},
                       n_full[wlrc_pkg::NUM_W-1:wlrc_pkg::KW_W]};
    assign over1    = nhi >= r_wsum;
    assign over2    = nhi >= r_d2;
    assign den_k    = {1'b0, r_item.conductivity, 3'b000}
                    + {3'b000, r_item.conductivity, 1'b0};
    assign part     = {32'b0, r_prod} << {idx, 4'b0000};
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    // Select multiplier operands
    always_comb begin
        mul_a = r_ma;
        mul_b = r_mb[idx*wlrc_pkg::FIELD_W +: wlrc_pkg::FIELD_W];
        unique case (r_state)
            S_P:     begin
                mul_a = {32'b0, r_item.density};
                mul_b = r_item.heat_capacity;
            end
            S_C:     begin
                mul_a = {16'b0, r_prod[31:0]};
                mul_b = r_item.thickness;
            end
            default: ;
        endcase
    end

    // Issue divider requests
    always_comb begin
        o_div_req = '0;
        unique case (r_state)
            S_P: begin
                o_div_req.start = !r_item.k_zero;
                o_div_req.steps = wlrc_pkg::DIV_STEPS_FULL;
                o_div_req.num   = {r_item.thickness, 32'b0};
                o_div_req.den   = {44'b0, den_k};
            end
            S_Q1: begin
                o_div_req.start = !(r_wsum == '0 || over1);
                o_div_req.steps = wlrc_pkg::DIV_STEPS_Q;
                o_div_req.num   = {n_full[wlrc_pkg::KW_W-1:0],
                                   {(wlrc_pkg::DNUM_W-wlrc_pkg::KW_W){1'b0}}};
                o_div_req.rem   = nhi;
                o_div_req.den   = r_wsum;
            end
            S_Q2: begin
                o_div_req.start = !(r_d2 == '0 || over2);
                o_div_req.steps = wlrc_pkg::DIV_STEPS_Q;
                o_div_req.num   = {n_full[wlrc_pkg::KW_W-1:0],
                                   {(wlrc_pkg::DNUM_W-wlrc_pkg::KW_W){1'b0}}};
                o_div_req.rem   = nhi;
                o_div_req.den   = r_d2;
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_q_valid) n_state = S_P;
            S_P:     n_state = S_C;
            S_C:     n_state = S_CW;
            S_CW:    n_state = S_RW;
            S_RW:    if (r_item.k_zero || i_div_rsp.done) n_state = S_MUL;
            S_MUL:   if (r_j == 3'd5) begin
                n_state = r_tc_pass ? S_TCAP : (r_rc_pass ? S_FIN : S_UPD);
            end
            S_UPD:   n_state = r_item.last_layer ? S_RCSET : S_IDLE;
            S_RCSET: n_state = S_MUL;
            S_FIN:   n_state = S_TCSET;
            S_TCSET: n_state = S_MUL;
            S_TCAP:  n_state = (r_err || r_csum == '0) ? S_OUT : S_Q1;
            S_Q1:    n_state = o_div_req.start ? S_Q1W : S_Q2;
            S_Q1W:   if (i_div_rsp.done) n_state = S_Q2;
            S_Q2:    n_state = o_div_req.start ? S_Q2W : S_OUT;
            S_Q2W:   if (i_div_rsp.done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Status with its priority order
    always_comb begin
        if (r_err)               n_st = wlrc_pkg::ST_ZCOND;
        else if (r_csum == '0)   n_st = wlrc_pkg::ST_ZCAP;
        else if (r_sat)          n_st = wlrc_pkg::ST_SAT;
        else                     n_st = wlrc_pkg::ST_OK;
    end

    // Control state, running sums and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_csum  <= '0;
            r_rsum  <= '0;
            r_wsum  <= '0;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                r_wsum <= wlrc_pkg::sat_add64(r_wsum, r_acc[wlrc_pkg::ACC_W-1:32]);
                r_csum <= wlrc_pkg::sat_add48(r_csum, r_c);
                r_rsum <= wlrc_pkg::sat_add48(r_rsum, r_r);
                if (r_item.k_zero) r_err <= 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_ov   <= 1'b1;
                r_csum <= '0;
                r_rsum <= '0;
                r_wsum <= '0;
                r_err  <= 1'b0;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * {32'b0, mul_b};
        unique case (r_state)
            S_IDLE:  if (i_q_valid) r_item <= i_q_item;
            S_CW:    r_c <= r_prod[wlrc_pkg::CAP_W-1:0];
            S_RW:    begin
                r_r       <= q_r;
                r_ma      <= r_c;
                r_mb      <= rmid;
                r_j       <= '0;
                r_acc     <= '0;
                r_rc_pass <= 1'b0;
                r_tc_pass <= 1'b0;
            end
            S_MUL:   begin
                r_j <= r_j + 1'b1;
                if (r_j[0]) r_acc <= r_acc + part;
            end
            S_RCSET: begin
                r_ma      <= r_csum;
                r_mb      <= r_rsum;
                r_j       <= '0;
                r_acc     <= '0;
                r_rc_pass <= 1'b1;
                r_tc_pass <= 1'b0;
            end
            S_FIN:   begin
                r_d2  <= (rc > r_wsum) ? rc - r_wsum : '0;
                r_sat <= r_csum == wlrc_pkg::CAP_MAX || r_rsum == wlrc_pkg::CAP_MAX
                      || r_wsum == wlrc_pkg::WSUM_MAX || rc == wlrc_pkg::WSUM_MAX;
                r_kw1 <= '0;
                r_kw2 <= '0;
            end
            // Scale the capacity by the reciprocal of 10000
            S_TCSET: begin
                r_ma      <= {{wlrc_pkg::CAP_PRE{1'b0}},
                              r_csum[wlrc_pkg::CAP_W-1:wlrc_pkg::CAP_PRE]};
                r_mb      <= wlrc_pkg::CAP_RECIP;
                r_j       <= '0;
                r_acc     <= '0;
                r_tc_pass <= 1'b1;
            end
            S_TCAP:  r_tcap <= r_acc[wlrc_pkg::TCAP_SHIFT+wlrc_pkg::TCAP_W-1:
                                     wlrc_pkg::TCAP_SHIFT];
            S_Q1:    if (!o_div_req.start) begin
                r_kw1 <= wlrc_pkg::KW_MAX;
                r_sat <= 1'b1;
            end
            S_Q1W:   if (i_div_rsp.done) r_kw1 <= i_div_rsp.quo[wlrc_pkg::KW_W-1:0];
            S_Q2:    if (!o_div_req.start) begin
                r_kw2 <= wlrc_pkg::KW_MAX;
                r_sat <= 1'b1;
            end
            S_Q2W:   if (i_div_rsp.done) r_kw2 <= i_div_rsp.quo[wlrc_pkg::KW_W-1:0];
            S_OUT:   if (out_free) begin
                r_o_tcap <= r_tcap;
                r_o_kw1  <= r_kw1;
                r_o_kw2  <= r_kw2;
                r_o_st   <= n_st;
            end
            default: ;
        endcase
    end

    assign o_valid             = r_ov;
    assign o_total_capacity    = r_o_tcap;
    assign o_outer_conductance = r_o_kw1;
    assign o_inner_conductance = r_o_kw2;
    assign o_status            = r_o_st;

endmodule
`default_nettype wire

// ----- tb/wall_layer_rc_lumping_test.sv -----
// Self-checking test of the wall layer RC lumping block: random layered walls
// in, predicted capacity, conductances and status compared per result.
// Depends on wlrc_pkg and the wall_layer_rc_lumping top level.
`default_nettype none
module wall_layer_rc_lumping_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] thickness;
        logic [15:0] conductivity;
        logic [15:0] density;
        logic [15:0] heat_capacity;
        logic        last_layer;
    } t_layer_in;

    typedef struct packed {
        logic [wlrc_pkg::TCAP_W-1:0] total_capacity;
        logic [wlrc_pkg::KW_W-1:0]   outer_conductance;
        logic [wlrc_pkg::KW_W-1:0]   inner_conductance;
        logic [wlrc_pkg::ST_W-1:0]   status;
    } t_wall_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [15:0] i_thickness = '0, i_conductivity = '0, i_density = '0, i_heat_capacity = '0;
    logic i_last_layer = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [wlrc_pkg::TCAP_W-1:0] o_total_capacity;
    logic [wlrc_pkg::KW_W-1:0] o_outer_conductance, o_inner_conductance;
    logic [wlrc_pkg::ST_W-1:0] o_status;

    wall_layer_rc_lumping dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Wall state of the predictor
    logic [63:0] cap_acc = '0, res_acc = '0;
    logic [63:0] wgt_acc = '0;
    logic        cond_err = 1'b0;

    t_layer_in    pending_layers[$];
    t_wall_result expected_walls[$];
    int  mismatches = 0;
    bit  stimulus_done = 1'b0;

    function automatic logic [63:0] mul_frac32(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return (p[127:96] != 0) ? '1 : p[95:32];
    endfunction

    function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
        logic [64:0] s;
        s = a + b;
        return (s > {1'b0, lim}) ? lim : s[63:0];
    endfunction

    function automatic logic [31:0] conductance(logic [63:0] cap, logic [63:0] d, ref bit sat);
        logic [127:0] q;
        q = ({64'd0, cap} << wlrc_pkg::OUT_FRAC_BITS) / d;
        if (q > 128'hFFFFFFFF) begin
            sat = 1'b1;
            return '1;
        end
        return q[31:0];
    endfunction

    // Append one layer to the request queue
    function automatic void queue_layer(t_layer_in l);
        pending_layers = {pending_layers, l};
    endfunction

    // Fold one layer into the wall sums; queue a result on the last layer
    function automatic void lump_layer(t_layer_in l);
        logic [63:0] c, r, rmid, rc, d2;
        t_wall_result w;
        bit sat;
        c = 64'(l.density) * l.heat_capacity * l.thickness;
        r = 0;
        if (l.conductivity == 0) cond_err = 1'b1;
        else r = ({48'd0, l.thickness} << 32) / (64'd10 * l.conductivity);
        rmid = add_clip(res_acc, r >> 1, 64'hFFFFFFFFFFFF);
        wgt_acc = add_clip(wgt_acc, mul_frac32(c, rmid), '1);
        cap_acc = add_clip(cap_acc, c, 64'hFFFFFFFFFFFF);
        res_acc = add_clip(res_acc, r, 64'hFFFFFFFFFFFF);
        if (!l.last_layer) return;
        w = '0;
        sat = (cap_acc == wlrc_pkg::CAP_MAX) || (res_acc == wlrc_pkg::CAP_MAX)
           || (wgt_acc == wlrc_pkg::WSUM_MAX);
        if (cond_err) w.status = wlrc_pkg::ST_ZCOND;
        else if (cap_acc == 0) w.status = wlrc_pkg::ST_ZCAP;
        else begin
            rc = mul_frac32(res_acc, cap_acc);
            d2 = (rc > wgt_acc) ? rc - wgt_acc : 0;
            if (rc == wlrc_pkg::WSUM_MAX) sat = 1'b1;
            if (wgt_acc == 0) begin
                w.outer_conductance = wlrc_pkg::KW_MAX;
                sat = 1'b1;
            end else w.outer_conductance = conductance(cap_acc, wgt_acc, sat);
            if (d2 == 0) begin
                w.inner_conductance = wlrc_pkg::KW_MAX;
                sat = 1'b1;
            end else w.inner_conductance = conductance(cap_acc, d2, sat);
            w.status = sat ? wlrc_pkg::ST_SAT : wlrc_pkg::ST_OK;
        end
        w.total_capacity = wlrc_pkg::TCAP_W'(cap_acc / 10000);
        expected_walls = {expected_walls, w};
        cap_acc = 0;
        res_acc = 0;
        wgt_acc = 0;
        cond_err = 1'b0;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        mismatches++;
    endtask

    function automatic t_layer_in random_layer(bit last);
        t_layer_in l;
        int m;
        m = $urandom_range(0, 9);
        l.thickness = (m < 2) ? 16'($urandom) : 16'($urandom_range(1, 3000));
        l.conductivity = (m == 3) ? 16'd0 : (m < 2) ? 16'($urandom) : 16'($urandom_range(20, 5000));
        l.density = (m < 2) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        l.heat_capacity = (m < 2) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        if ($urandom_range(0, 19) == 0) l.density = 0;
        l.last_layer = last;
        return l;
    endfunction

    // Fill the request queue: directed walls, then random walls
    initial begin
        int n, k;
        queue_layer('{16'd1, 16'd1, 16'd0, 16'd0, 1'b1});
        queue_layer('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
        queue_layer('{16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 1'b0});
        queue_layer('{16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 1'b1});
        queue_layer('{16'd200, 16'd0, 16'd1500, 16'd900, 1'b0});
        queue_layer('{16'd100, 16'd800, 16'd2000, 16'd1000, 1'b1});
        queue_layer('{16'd0, 16'd500, 16'd2000, 16'd1000, 1'b1});
        queue_layer('{16'd150, 16'd1000, 16'd2400, 16'd880, 1'b0});
        queue_layer('{16'd800, 16'd40, 16'd30, 16'd1400, 1'b0});
        queue_layer('{16'd120, 16'd700, 16'd1800, 16'd840, 1'b1});
        queue_layer('{16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF, 1'b1});
        queue_layer('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1});
        queue_layer('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1});
        queue_layer('{16'd1, 16'hFFFF, 16'd1, 16'd1, 1'b1});
        n = pending_layers.size();
        while (n < 750) begin
            k = $urandom_range(1, 6);
            for (int i = 1; i <= k; i++) queue_layer(random_layer(i == k));
            n += k;
        end
        stimulus_done = 1'b1;
    end

    // Release reset
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: present one request at a time with a random gap before each
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                lump_layer(pending_layers.pop_front());
                send_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
            if (!(i_valid && o_stall)) begin
                if (send_gap == 0 && pending_layers.size() > 0) begin
                    i_valid <= 1'b1;
                    {i_thickness, i_conductivity, i_density, i_heat_capacity,
                     i_last_layer} <= pending_layers[0];
                end else begin
                    i_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end
            end
        end
    end

    // Monitor: stall at random, check each accepted result
    int hold = 0;
    always @(posedge i_clk) begin
        t_wall_result w;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_walls.size() == 0) begin
                    report_mismatch("unexpected result", 64'd0, 64'd0);
                end else begin
                    w = expected_walls.pop_front();
                    if (o_total_capacity !== w.total_capacity)
                        report_mismatch("total_capacity", 64'(o_total_capacity),
                                        64'(w.total_capacity));
                    if (o_outer_conductance !== w.outer_conductance)
                        report_mismatch("outer_conductance", 64'(o_outer_conductance),
                                        64'(w.outer_conductance));
                    if (o_inner_conductance !== w.inner_conductance)
                        report_mismatch("inner_conductance", 64'(o_inner_conductance),
                                        64'(w.inner_conductance));
                    if (o_status !== w.status)
                        report_mismatch("status", 64'(o_status), 64'(w.status));
                end
                hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else i_stall <= 1'b0;
        end
    end

    // Wait for the queues to drain, then allow the last result to settle
    initial begin
        wait (stimulus_done && i_rst_n);
        wait (pending_layers.size() == 0 && !i_valid);
        wait (expected_walls.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_walls.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    // Hard limit on the run
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
